// ===== src/bibod_pkg.sv =====
// Shared types and constants of the binary image block-OR downscaler.
`default_nettype none

package bibod_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } bibod_reg_t;

  // Register widths and reset values.
  localparam int unsigned SCALE_W    = 8;
  localparam int unsigned DIM_W      = 11;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd1;
  localparam logic [DIM_W-1:0]   DIM_RESET   = 11'd1024;
  localparam int unsigned MAX_SCALE = 255;

  // Input byte codes.
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  // Decoupling queue between front and back.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // Per-pixel control flags decided by the front part.
  typedef struct packed {
    logic fresh;      // first pixel of a block: accumulator starts clean
    logic one;        // byte is a one
    logic bad;        // byte is neither zero nor one
    logic emit;       // pixel closes its block
    logic row_end;    // pixel closes an input row
    logic frame_end;  // pixel closes the frame
  } bibod_flags_t;

endpackage

`default_nettype wire

// ===== src/bibod_fifo.sv =====
// Short queue that decouples the front part from the back part.
`default_nettype none

module bibod_fifo #(
  parameter int unsigned DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      head_data,
  output logic                   full,
  output logic                   empty
);
  import bibod_pkg::*;

  logic [DATA_W-1:0]     mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue fill count beyond its depth");

endmodule

`default_nettype wire

// ===== src/bibod_front.sv =====
// Front part: configuration registers, raster position counters and pixel classification.
`default_nettype none

module bibod_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  input  wire logic [bibod_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bibod_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [7:0]                           in_pixel_char,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] q_idx,
  output bibod_pkg::bibod_flags_t                   q_flags
);
  import bibod_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  function automatic logic [31:0] clamp_reg(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Registers hold the clamped value minus one, ready for the end compares.
  logic [SCALE_W-1:0] sm1_r;
  logic [CW-1:0]      wm1_r;
  logic [RW-1:0]      hm1_r;

  logic [CW-1:0]      col_pos_r,  col_pos_nxt;
  logic [RW-1:0]      row_pos_r,  row_pos_nxt;
  logic [SCALE_W-1:0] cib_r,      cib_nxt;
  logic [SCALE_W-1:0] rib_r,      rib_nxt;
  logic [CW-1:0]      ocol_r,     ocol_nxt;

  logic row_end, frame_end, col_blk_end, row_blk_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm1_r <= SCALE_W'(clamp_reg(32'(SCALE_RESET), 32'(MAX_SCALE)) - 32'd1);
      wm1_r <= CW'(clamp_reg(32'(DIM_RESET), 32'(MAX_WIDTH)) - 32'd1);
      hm1_r <= RW'(clamp_reg(32'(DIM_RESET), 32'(MAX_HEIGHT)) - 32'd1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCALE:
          sm1_r <= SCALE_W'(clamp_reg(32'(cfg_data[SCALE_W-1:0]), 32'(MAX_SCALE)) - 32'd1);
        REG_WIDTH:  wm1_r <= CW'(clamp_reg(32'(cfg_data), 32'(MAX_WIDTH)) - 32'd1);
        REG_HEIGHT: hm1_r <= RW'(clamp_reg(32'(cfg_data), 32'(MAX_HEIGHT)) - 32'd1);
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign q_idx    = ocol_r;

  // Positions are compared as "at or past the end" so that shrinking a
  // dimension mid-frame closes the current block, row or frame at once.
  always_comb begin
    row_end     = (col_pos_r >= wm1_r);
    frame_end   = row_end && (row_pos_r >= hm1_r);
    col_blk_end = row_end || (cib_r >= sm1_r);
    row_blk_end = (row_pos_r >= hm1_r) || (rib_r >= sm1_r);

    q_flags.fresh     = (cib_r == '0) && (rib_r == '0);
    q_flags.one       = (in_pixel_char == CHAR_ONE);
    q_flags.bad       = (in_pixel_char != CHAR_ONE) && (in_pixel_char != CHAR_ZERO);
    q_flags.emit      = col_blk_end && row_blk_end;
    q_flags.row_end   = row_end;
    q_flags.frame_end = frame_end;
  end

  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    cib_nxt     = cib_r;
    rib_nxt     = rib_r;
    ocol_nxt    = ocol_r;
    if (row_end) begin
      col_pos_nxt = '0;
      cib_nxt     = '0;
      ocol_nxt    = '0;
      if (frame_end) begin
        row_pos_nxt = '0;
        rib_nxt     = '0;
      end else begin
        row_pos_nxt = row_pos_r + 1'b1;
        rib_nxt     = row_blk_end ? '0 : rib_r + 1'b1;
      end
    end else begin
      col_pos_nxt = col_pos_r + 1'b1;
      if (col_blk_end) begin
        cib_nxt  = '0;
        ocol_nxt = ocol_r + 1'b1;
      end else begin
        cib_nxt = cib_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      cib_r     <= '0;
      rib_r     <= '0;
      ocol_r    <= '0;
    end else if (q_push) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      cib_r     <= cib_nxt;
      rib_r     <= rib_nxt;
      ocol_r    <= ocol_nxt;
    end
  end

  a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_flags.frame_end |=> (col_pos_r == '0) && (row_pos_r == '0) && (ocol_r == '0))
    else $error("raster counters did not wrap at the end of the frame");

endmodule

`default_nettype wire

// ===== src/bibod_back.sv =====
// Back part: column accumulator memory read-modify-write and the output register.
`default_nettype none

module bibod_back #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 q_empty,
  input  wire logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] q_idx,
  input  wire bibod_pkg::bibod_flags_t              q_flags,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_pixel,
  output logic                                      out_bad_char,
  output logic                                      out_end_of_row,
  output logic                                      out_end_of_frame
);
  import bibod_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // One entry per output column: bit 0 is the OR of ones, bit 1 a bad byte seen.
  logic [1:0]   acc_mem [MAX_WIDTH];
  logic [1:0]   rdata_r;

  logic         b1_vld_r;
  logic [CW-1:0] b1_idx_r;
  bibod_flags_t b1_flags_r;

  logic         b2_vld_r;
  logic [CW-1:0] b2_idx_r;
  bibod_flags_t b2_flags_r;
  logic [1:0]   b2_old_r, b2_old_nxt;

  logic         lw_vld_r;
  logic [CW-1:0] lw_idx_r;
  logic [1:0]   lw_val_r;

  logic         out_valid_r;
  logic         out_pixel_r, out_bad_r, out_eor_r, out_eof_r;

  logic         adv;
  logic [1:0]   acc_new;

  assign adv     = !(b2_vld_r && b2_flags_r.emit && out_valid_r && !out_ready);
  assign q_pop   = adv && !q_empty;
  assign acc_new = (b2_flags_r.fresh ? 2'b00 : b2_old_r) | {b2_flags_r.bad, b2_flags_r.one};

  // The memory read for the stage-one item misses the write made in the same
  // cycle and the one made as it moves on, so both are forwarded here.
  always_comb begin
    if (b2_vld_r && (b2_idx_r == b1_idx_r)) begin
      b2_old_nxt = acc_new;
    end else if (lw_vld_r && (lw_idx_r == b1_idx_r)) begin
      b2_old_nxt = lw_val_r;
    end else begin
      b2_old_nxt = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= acc_mem[q_idx];
      if (b2_vld_r) begin
        acc_mem[b2_idx_r] <= acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r    <= 1'b0;
      b2_vld_r    <= 1'b0;
      lw_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        b1_vld_r <= !q_empty;
        b2_vld_r <= b1_vld_r;
        lw_vld_r <= b2_vld_r;
      end
      if (adv && b2_vld_r && b2_flags_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_idx_r   <= q_idx;
      b1_flags_r <= q_flags;
      b2_idx_r   <= b1_idx_r;
      b2_flags_r <= b1_flags_r;
      b2_old_r   <= b2_old_nxt;
      lw_idx_r   <= b2_idx_r;
      lw_val_r   <= acc_new;
    end
    if (adv && b2_vld_r && b2_flags_r.emit) begin
      out_pixel_r <= acc_new[0];
      out_bad_r   <= acc_new[1];
      out_eor_r   <= b2_flags_r.row_end;
      out_eof_r   <= b2_flags_r.frame_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel        = out_pixel_r;
  assign out_bad_char     = out_bad_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    b2_vld_r && b2_flags_r.emit && out_valid_r && !out_ready
    |=> b2_vld_r && $stable(b2_idx_r) && $stable(b2_old_r))
    else $error("finishing stage moved on while the output register was full");

  a_eof_has_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eof_r |-> out_eor_r)
    else $error("end of frame without end of row");

  a_pop_only_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> adv && !q_empty)
    else $error("queue popped while the back part was stalled");

endmodule

`default_nettype wire

// ===== src/binary_image_block_or_downscale_top.sv =====
// Top level of the binary image block-OR downscaler.
//
// Input pixels arrive as ASCII bytes in raster order on the in_ channel, one
// transfer per pixel. The picture is cut into scale by scale blocks (short at
// the right and bottom edges), and each block yields one output transfer on
// the out_ channel carrying the OR of its ones, a bad-byte flag and
// end-of-row / end-of-frame marks, sent when the block's last pixel arrives.
// The cfg_ channel writes scale factor (index 0), image width (1) and image
// height (2); cfg_ready is always high, so a write is taken when offered.
// Configuration is meant to change only while the block is idle.
// Throughput is one pixel per cycle while the receiver keeps up: the
// per-column accumulator memory does one read-modify-write per pixel, with
// forwarding between its read and write stages. The pixel that closes a block
// passes through the queue, stage one and the finishing stage before its result
// is held by the output register until out_ready takes it.
// When the receiver stalls, the back part holds and a four-entry queue keeps
// taking pixels until it fills; in_ready then drops.
// Reset (synchronous, active low) restores the default registers, clears all
// positions and empties the queue and pipeline; the accumulator memory needs
// no clearing because the first pixel of each block overwrites its entry.
`default_nettype none

module binary_image_block_or_downscale_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bibod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bibod_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       in_pixel_char,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_pixel,
  output logic                                  out_bad_char,
  output logic                                  out_end_of_row,
  output logic                                  out_end_of_frame
);
  import bibod_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned QW = CW + $bits(bibod_flags_t);

  logic          push, pop, q_full, q_empty;
  logic [CW-1:0] push_idx, head_idx;
  bibod_flags_t  push_flags, head_flags;
  logic [QW-1:0] push_data, head_data;

  // Register writes are always taken in the cycle they are offered.
  assign cfg_ready = 1'b1;

  // Front part: keeps the raster position and decides, per pixel, which
  // accumulator column it updates and whether it closes a block.
  bibod_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_char (in_pixel_char),
    .q_full        (q_full),
    .q_push        (push),
    .q_idx         (push_idx),
    .q_flags       (push_flags)
  );

  assign push_data = {push_idx, push_flags};

  bibod_fifo #(
    .DATA_W (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign head_idx   = head_data[QW-1 -: CW];
  assign head_flags = bibod_flags_t'(head_data[$bits(bibod_flags_t)-1:0]);

  // Back part: accumulates each pixel into its column entry and presents the
  // finished block through the output register.
  bibod_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_idx            (head_idx),
    .q_flags          (head_flags),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel        (out_pixel),
    .out_bad_char     (out_bad_char),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

`default_nettype wire
